FILE: rtl/dstg_pkg.sv
// Shared constants, types and the quarter-wave sine table for the tone generator.
`default_nettype none

package dstg_pkg;

  // Sizes of the datapath
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int LENGTH_BITS     = 16;

  localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
  localparam int ROM_DEPTH    = (1 << QUARTER_BITS) + 1;
  localparam int ROM_IDX_W    = QUARTER_BITS + 1;

  // Register widths and the configuration port
  localparam int STEP_W     = 31;
  localparam int DECAY_W    = 16;
  localparam int TLEN_W     = 16;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_LENGTH  = 2'd2;

  // Envelope and amplitude
  localparam int ENV_W = 16;
  localparam logic [ENV_W-1:0] ENV_ONE = 16'hFFFF;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'hFFFF;
  localparam int AMPLITUDE = 30000;
  // Table entries already carry the 30000 amplitude: 30000 * 32768 fits in 30 bits
  localparam int AMP_W    = 30;
  localparam int PROD_W   = AMP_W + ENV_W;
  localparam int PROD_SH  = 31;
  localparam int MAG_W    = PROD_W - PROD_SH;
  localparam int SAMPLE_W = 16;

  // Polynomial coefficients of the quarter sine, Q30
  localparam logic [63:0] K1 = 64'd1686629713;
  localparam logic [63:0] K3 = 64'd693598669;
  localparam logic [63:0] K5 = 64'd85569306;
  localparam logic [63:0] K7 = 64'd5026995;
  localparam logic [63:0] K9 = 64'd172272;

  typedef logic [AMP_W-1:0] rom_t [ROM_DEPTH];

  // One sample's worth of work handed from the control stage to the output stage
  typedef struct packed {
    logic             active;
    logic             last;
    logic             neg;
    logic [AMP_W-1:0] amp;
    logic [ENV_W-1:0] env;
  } tick_t;

  // Build the scaled quarter-wave table at elaboration
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] q;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      x  = 64'(i) << (16 - QUARTER_BITS);
      x2 = (x * x) >> 16;
      t  = K9;
      t  = K7 - ((x2 * t) >> 16);
      t  = K5 - ((x2 * t) >> 16);
      t  = K3 - ((x2 * t) >> 16);
      t  = K1 - ((x2 * t) >> 16);
      t  = (x * t) >> 16;
      q  = (t + 64'd16384) >> 15;
      rom[i] = AMP_W'(q * 64'(AMPLITUDE));
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

`default_nettype wire

FILE: rtl/dstg_ctrl.sv
// Configuration registers, tone state, envelope decay and sine table lookup.
`default_nettype none

module dstg_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dstg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dstg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            fire_i,
  input  wire logic                            restart_i,
  output dstg_pkg::tick_t                      tick_o
);

  localparam int PB = dstg_pkg::PHASE_BITS;
  localparam int LB = dstg_pkg::LENGTH_BITS;
  localparam int TB = dstg_pkg::TABLE_ADDR_BITS;
  localparam int QB = dstg_pkg::QUARTER_BITS;

  logic [dstg_pkg::STEP_W-1:0]  step_q;
  logic [dstg_pkg::DECAY_W-1:0] decay_q;
  logic [dstg_pkg::TLEN_W-1:0]  tlen_q;

  logic [PB-1:0]                phase_q, phase_d;
  logic [dstg_pkg::ENV_W-1:0]   env_q, env_d;
  logic [LB-1:0]                left_q, left_d;
  logic                         run_q, run_d;

  logic [PB-1:0]                ph_eff;
  logic [dstg_pkg::ENV_W-1:0]   env_eff;
  logic [LB-1:0]                left_eff;
  logic [LB-1:0]                left_dec;
  logic [LB-1:0]                len;
  logic                         run_eff;
  logic                         is_last;
  logic [TB-1:0]                addr;
  logic [QB-1:0]                pos;
  logic [dstg_pkg::ROM_IDX_W-1:0] rom_idx;
  logic [2*dstg_pkg::ENV_W-1:0] env_prod;

  // Write configuration registers; unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      decay_q <= dstg_pkg::DECAY_RESET;
      tlen_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dstg_pkg::REG_PHASE_STEP:   step_q  <= cfg_data_i[dstg_pkg::STEP_W-1:0];
        dstg_pkg::REG_DECAY_FACTOR: decay_q <= cfg_data_i[dstg_pkg::DECAY_W-1:0];
        dstg_pkg::REG_TONE_LENGTH:  tlen_q  <= cfg_data_i[dstg_pkg::TLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Apply restart, then form this sample's lookup and the next state
  always_comb begin
    len      = LB'(tlen_q);
    ph_eff   = restart_i ? '0 : phase_q;
    env_eff  = restart_i ? dstg_pkg::ENV_ONE : env_q;
    left_eff = restart_i ? len : left_q;
    run_eff  = restart_i ? (len != '0) : run_q;

    left_dec = left_eff - LB'(1);
    is_last  = (left_dec == '0);

    addr    = ph_eff[PB-1 -: TB];
    pos     = addr[QB-1:0];
    rom_idx = addr[TB-2] ? ((dstg_pkg::ROM_IDX_W'(1) << QB) - {1'b0, pos}) : {1'b0, pos};

    env_prod = env_eff * decay_q;

    tick_o.active = run_eff;
    tick_o.last   = run_eff & is_last;
    tick_o.neg    = addr[TB-1];
    tick_o.amp    = dstg_pkg::SINE_ROM[rom_idx];
    tick_o.env    = env_eff;

    phase_d = run_eff ? (ph_eff + PB'(step_q)) : ph_eff;
    env_d   = run_eff ? env_prod[2*dstg_pkg::ENV_W-1 -: dstg_pkg::ENV_W] : env_eff;
    left_d  = run_eff ? left_dec : left_eff;
    run_d   = run_eff & ~is_last;
  end

  // Advance tone state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      env_q   <= '0;
      left_q  <= '0;
      run_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      env_q   <= env_d;
      left_q  <= left_d;
      run_q   <= run_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dstg_out.sv
// Two-stage output pipeline: envelope multiply, sign and result register.
`default_nettype none

module dstg_out (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire dstg_pkg::tick_t                       tick_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [dstg_pkg::SAMPLE_W-1:0]       sample_o,
  output logic                                       active_o,
  output logic                                       last_o
);

  dstg_pkg::tick_t                     a_q;
  logic                                a_valid_q;
  logic                                o_valid_q;
  logic                                o_free;
  logic                                a_adv;
  logic [dstg_pkg::PROD_W-1:0]         prod;
  logic [dstg_pkg::MAG_W-1:0]          mag;
  logic [dstg_pkg::SAMPLE_W-1:0]       sample_d;
  logic [dstg_pkg::SAMPLE_W-1:0]       sample_q;
  logic                                active_q;
  logic                                last_q;

  // Move an item forward whenever the slot ahead is empty or draining
  assign o_free     = ~o_valid_q | out_ready_i;
  assign a_adv      = a_valid_q & o_free;
  assign in_ready_o = ~a_valid_q | a_adv;

  // Scale the table value by the envelope and apply the sign
  always_comb begin
    prod     = a_q.amp * a_q.env;
    mag      = prod[dstg_pkg::PROD_W-1 -: dstg_pkg::MAG_W];
    sample_d = dstg_pkg::SAMPLE_W'(mag);
    if (a_q.neg) begin
      sample_d = -sample_d;
    end
    if (!a_q.active) begin
      sample_d = '0;
    end
  end

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q <= tick_i;
    end
    if (a_adv) begin
      sample_q <= sample_d;
      active_q <= a_q.active;
      last_q   <= a_q.last;
    end
  end

  assign out_valid_o = o_valid_q;
  assign sample_o    = sample_q;
  assign active_o    = active_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

FILE: rtl/decaying_sine_tone_generator_top.sv
// Top level of the decaying sine tone generator.
//
//   channel   direction  handshake                   payload
//   input     in         in_valid_i / in_ready_o     restart_i
//   output    out        out_valid_o / out_ready_i   sample_o, active_o, last_o
//   config    in         cfg_we_i (no wait)          cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_ready_i is high. State update and
// table read happen at acceptance, the envelope multiply after the middle stage.
// Tone state advances at acceptance, so back-to-back items chain with no gap.
// Reset clears the tone state to idle and sets decay_factor to one.
// A stalled output keeps the result; one more item is taken into the middle
// stage before in_ready_o drops.
`default_nettype none

module decaying_sine_tone_generator_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dstg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dstg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            restart_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [dstg_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                 active_o,
  output logic                                 last_o
);

  dstg_pkg::tick_t tick;
  logic            fire;

  assign fire = in_valid_i & in_ready_o;

  dstg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .restart_i   (restart_i),
    .tick_o      (tick)
  );

  dstg_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .tick_i      (tick),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .active_o    (active_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

FILE: rtl/dstg_checker.sv
// Port-level checks for the tone generator, bound to the top level.
`default_nettype none

module dstg_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_ready_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic signed [dstg_pkg::SAMPLE_W-1:0] sample_o,
  input wire logic                            active_o,
  input wire logic                            last_o
);

  // Idle results are silent and never flagged last
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_o |-> sample_o == '0 && !last_o)
    else $error("idle result carries a sample or last flag");

  // Samples stay within the amplitude
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_o <= 16'sd30000 && sample_o >= -16'sd30000)
    else $error("sample outside amplitude range");

  // Input stalls only when the result register is held by the consumer
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a held result");

  // A held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o) && $stable(last_o))
    else $error("held result changed");

endmodule

bind decaying_sine_tone_generator_top dstg_checker u_dstg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sample_o    (sample_o),
  .active_o    (active_o),
  .last_o      (last_o)
);

`default_nettype wire
